@@ src/pcsc_pkg.sv @@
// ============================================================================
// pcsc_pkg
// Shared types and constants of the pump contactor safety controller. It holds
// the transaction payload structs, the command, status and fault codes, and
// the configuration register indexes.
// ============================================================================
package pcsc_pkg;

    localparam int DEBOUNCE_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int TIMER_W = 26;

    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP = 3'd2;
    localparam logic [2:0] CMD_AUTO = 3'd3;
    localparam logic [2:0] CMD_MANUAL = 3'd4;
    localparam logic [2:0] CMD_FAULT_RESET = 3'd5;

    localparam logic [1:0] STATUS_IDLE = 2'd0;
    localparam logic [1:0] STATUS_RUNNING = 2'd1;
    localparam logic [1:0] STATUS_FAULT = 2'd2;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_OVERLOAD = 2'd1;
    localparam logic [1:0] FAULT_TIMEOUT = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RUN_SECONDS = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DRY_LOCKOUT_SECONDS = 8'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MS_RESET = 16'd50;
    localparam logic [TIMER_W-1:0] RUN_LIMIT_MS_RESET = 26'd3600000;
    localparam logic [TIMER_W-1:0] LOCKOUT_LOAD_MS_RESET = 26'd300000;
    localparam logic [TIMER_W-1:0] MS_PER_SECOND = 26'd1000;

    typedef struct packed {
        logic [2:0] command;
        logic       tank_low_raw;
        logic       tank_high_raw;
        logic       overload_raw;
        logic       sump_low_wet;
    } item_t;

    typedef struct packed {
        logic       motor_on;
        logic [1:0] system_status;
        logic [1:0] fault_cause;
        logic       manual_mode;
        logic       tank_low;
        logic       tank_high;
        logic       overload_tripped;
        logic       command_rejected;
    } result_t;

endpackage

@@ src/pump_contactor_safety_controller_unit.sv @@
// ============================================================================
// pump_contactor_safety_controller_unit
// Pump contactor safety controller, one transaction per millisecond tick.
// Debounces the floats and the overload sense, runs the automatic and manual
// pump logic with fault latching, dry-sump lockout and tank-full latch, and
// then applies the operator command.
//
//   Channel   Signals                                   Direction
//   item      item_valid, item_stall, item (item_t)     in
//   result    result_valid, result_stall, result        out
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in
//
// Each item is taken into an input register, its tick is evaluated from that
// register and the result lands in the output register when that can advance;
// one item is taken per clock while item_stall is low.
// The output register frees itself in the cycle it is taken; item_stall rises
// only when both the input and the output register are full and result_stall
// is high. Reset restores the default configuration and clears all state but the item and result data registers.
// ============================================================================
module pump_contactor_safety_controller_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  pcsc_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output pcsc_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pcsc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pcsc_pkg::*;

    logic                  item_valid_reg;
    item_t                 item_reg;
    logic                  result_valid_reg;
    result_t               result_reg;
    result_t               result_next;
    logic                  advance;
    logic                  step;

    logic [DEBOUNCE_W-1:0] debounce_ms_reg;
    logic [TIMER_W-1:0]    run_limit_ms_reg;
    logic [TIMER_W-1:0]    lockout_load_ms_reg;
    logic [TIMER_W-1:0]    cfg_ms;

    logic                  motor_running_reg;
    logic                  motor_running_next;
    logic                  manual_reg;
    logic                  manual_next;
    logic [1:0]            fault_reg;
    logic [1:0]            fault_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic                  full_latch_reg;
    logic                  full_latch_next;
    logic [TIMER_W-1:0]    lockout_reg;
    logic [TIMER_W-1:0]    lockout_next;
    logic [TIMER_W-1:0]    elapsed_reg;
    logic [TIMER_W-1:0]    elapsed_next;

    logic                  low_stable;
    logic                  high_stable;
    logic                  ovl_stable;

    assign advance = !result_valid_reg || !result_stall;
    assign step = item_valid_reg && advance;
    assign item_stall = item_valid_reg && !advance;
    assign result_valid = result_valid_reg;
    assign result = result_reg;
    assign cfg_ready = 1'b1;
    assign cfg_ms = TIMER_W'(cfg_data) * MS_PER_SECOND;

    pcsc_debounce u_low
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .raw         (item_reg.tank_low_raw),
        .debounce_ms (debounce_ms_reg),
        .stable      (low_stable)
    );

    pcsc_debounce u_high
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .raw         (item_reg.tank_high_raw),
        .debounce_ms (debounce_ms_reg),
        .stable      (high_stable)
    );

    pcsc_debounce u_ovl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .raw         (item_reg.overload_raw),
        .debounce_ms (debounce_ms_reg),
        .stable      (ovl_stable)
    );

    always_comb
    begin
        logic sump;
        logic rejected;
        logic can_start;
        sump = item_reg.sump_low_wet;
        rejected = 1'b0;
        motor_running_next = motor_running_reg;
        manual_next = manual_reg;
        fault_next = fault_reg;
        status_next = status_reg;
        full_latch_next = full_latch_reg;
        elapsed_next = elapsed_reg;
        lockout_next = (lockout_reg != '0) ? lockout_reg - TIMER_W'(1) : lockout_reg;

        if (motor_running_next && elapsed_next != '1)
        begin
            elapsed_next = elapsed_next + TIMER_W'(1);
        end
        if (ovl_stable)
        begin
            motor_running_next = 1'b0;
            fault_next = FAULT_OVERLOAD;
        end

        if (fault_next != FAULT_NONE)
        begin
            motor_running_next = 1'b0;
            status_next = STATUS_FAULT;
        end
        else if (motor_running_next && run_limit_ms_reg != '0
                 && elapsed_next >= run_limit_ms_reg)
        begin
            motor_running_next = 1'b0;
            fault_next = FAULT_TIMEOUT;
            status_next = STATUS_FAULT;
        end
        else
        begin
            if (!manual_next)
            begin
                if (low_stable)
                begin
                    full_latch_next = 1'b0;
                end
                if (!motor_running_next)
                begin
                    if (low_stable && sump && !full_latch_next && lockout_next == '0)
                    begin
                        motor_running_next = 1'b1;
                        elapsed_next = '0;
                    end
                end
                else if (high_stable)
                begin
                    motor_running_next = 1'b0;
                    full_latch_next = 1'b1;
                end
                else if (!sump)
                begin
                    motor_running_next = 1'b0;
                    lockout_next = lockout_load_ms_reg;
                end
            end
            else if (motor_running_next)
            begin
                if (high_stable)
                begin
                    motor_running_next = 1'b0;
                end
                else if (!sump)
                begin
                    motor_running_next = 1'b0;
                    lockout_next = lockout_load_ms_reg;
                end
            end
            status_next = motor_running_next ? STATUS_RUNNING : STATUS_IDLE;
        end

        can_start = !motor_running_next && !ovl_stable && sump && lockout_next == '0;

        case (item_reg.command)
            CMD_NONE:
            begin
            end
            CMD_START:
            begin
                manual_next = 1'b1;
                if (can_start)
                begin
                    motor_running_next = 1'b1;
                    elapsed_next = '0;
                end
            end
            CMD_STOP:
            begin
                motor_running_next = 1'b0;
            end
            CMD_AUTO:
            begin
                manual_next = 1'b0;
            end
            CMD_MANUAL:
            begin
                manual_next = 1'b1;
                motor_running_next = 1'b0;
            end
            CMD_FAULT_RESET:
            begin
                if (ovl_stable)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    fault_next = FAULT_NONE;
                end
            end
            default:
            begin
                rejected = 1'b1;
            end
        endcase

        result_next.motor_on = motor_running_next;
        result_next.system_status = status_next;
        result_next.fault_cause = fault_next;
        result_next.manual_mode = manual_next;
        result_next.tank_low = low_stable;
        result_next.tank_high = high_stable;
        result_next.overload_tripped = ovl_stable;
        result_next.command_rejected = rejected;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg <= DEBOUNCE_MS_RESET;
            run_limit_ms_reg <= RUN_LIMIT_MS_RESET;
            lockout_load_ms_reg <= LOCKOUT_LOAD_MS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEBOUNCE_MS:
                begin
                    debounce_ms_reg <= cfg_data;
                end
                REG_MAX_RUN_SECONDS:
                begin
                    run_limit_ms_reg <= cfg_ms;
                end
                REG_DRY_LOCKOUT_SECONDS:
                begin
                    lockout_load_ms_reg <= cfg_ms;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_running_reg <= 1'b0;
            manual_reg <= 1'b0;
            fault_reg <= FAULT_NONE;
            status_reg <= STATUS_IDLE;
            full_latch_reg <= 1'b0;
            lockout_reg <= '0;
            elapsed_reg <= '0;
        end
        else if (step)
        begin
            motor_running_reg <= motor_running_next;
            manual_reg <= manual_next;
            fault_reg <= fault_next;
            status_reg <= status_next;
            full_latch_reg <= full_latch_next;
            lockout_reg <= lockout_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

@@ src/pcsc_debounce.sv @@
// ============================================================================
// pcsc_debounce
// Debounce filter for one raw level. A change clears the stability counter;
// the level is accepted once it has stayed unchanged for debounce_ms ticks.
// The stable output shows the value after the current tick.
// ============================================================================
module pcsc_debounce
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic                             raw,
    input  logic [pcsc_pkg::DEBOUNCE_W-1:0]  debounce_ms,
    output logic                             stable
);
    import pcsc_pkg::*;

    logic                  last_reg;
    logic                  last_next;
    logic                  stable_reg;
    logic                  stable_next;
    logic [DEBOUNCE_W-1:0] elapsed_reg;
    logic [DEBOUNCE_W-1:0] elapsed_next;

    always_comb
    begin
        last_next = last_reg;
        stable_next = stable_reg;
        elapsed_next = elapsed_reg;
        if (raw != last_reg)
        begin
            last_next = raw;
            elapsed_next = '0;
        end
        else
        begin
            if (elapsed_reg != '1)
            begin
                elapsed_next = elapsed_reg + DEBOUNCE_W'(1);
            end
            if (raw != stable_reg && elapsed_next >= debounce_ms)
            begin
                stable_next = raw;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b0;
            stable_reg <= 1'b0;
            elapsed_reg <= '0;
        end
        else if (step)
        begin
            last_reg <= last_next;
            stable_reg <= stable_next;
            elapsed_reg <= elapsed_next;
        end
    end

    assign stable = stable_next;

endmodule
